// ===== hdl/crs_pkg.sv =====
// ----------------------------------------------------------------------------
// crs_pkg: shared constants and types for the cosh rejection sampler
// Division constants, polynomial coefficients and word widths.
// ----------------------------------------------------------------------------
package crs_pkg;

    localparam int ArgW = 23;
    localparam int RndW = 40;
    localparam int MagW = 23;

    // exp pipe: 7 division, 1 fix-up, 9 Horner steps of 2, 4 correction
    localparam int ExpDepth = 30;

    localparam logic [63:0] DivLn2 = 64'd16404853;
    localparam logic [63:0] Corr   = 64'd17933;

    localparam logic [63:0] PolyC0 = 64'd809438661408;
    localparam logic [63:0] PolyTop = 64'd2199023255552;

    typedef logic [63:0] word_t;

    // Horner coefficient subtracted at step k (k = 1..8)
    function automatic word_t poly_coef(input logic [3:0] k);
        word_t c;
        unique case (k)
            4'd1:    c = 64'd869506949331;
            4'd2:    c = 64'd640044208952;
            4'd3:    c = 64'd793458686015;
            4'd4:    c = 64'd839743192604;
            4'd5:    c = 64'd740389683060;
            4'd6:    c = 64'd1044449863563;
            4'd7:    c = 64'd552517269260;
            4'd8:    c = 64'd779422325990;
            default: c = 64'd0;
        endcase
        return c;
    endfunction

    // Shift after each Horner multiply (k = 0..8)
    function automatic logic [4:0] poly_shift(input logic [3:0] k);
        logic [4:0] s;
        unique case (k)
            4'd0, 4'd1:             s = 5'd28;
            4'd2, 4'd3, 4'd4, 4'd6: s = 5'd27;
            4'd5:                   s = 5'd26;
            4'd7:                   s = 5'd25;
            4'd8:                   s = 5'd23;
            default:                s = 5'd0;
        endcase
        return s;
    endfunction

    // Sign-extended exponent width; exponents span -87..168
    localparam int ExpW = 10;
    typedef logic signed [ExpW-1:0] exp_t;

endpackage

// ===== hdl/crs_exp_pipe.sv =====
// ----------------------------------------------------------------------------
// crs_exp_pipe: pipelined exp evaluation
// Seven division steps and the fix-up one stage each; every Horner multiply
// and the final correction multiply take two stages (32-bit partial products,
// then sum). The stall enable freezes every stage.
// ----------------------------------------------------------------------------
module crs_exp_pipe (
    input  logic                   aclk,
    input  logic                   en,
    input  logic [crs_pkg::MagW-1:0] mag,
    input  logic                   nonneg,
    output crs_pkg::word_t         p,
    output crs_pkg::exp_t          ex
);
    localparam int Depth = crs_pkg::ExpDepth;
    localparam int PolyS = 8;           // first Horner stage
    localparam int CorrS = PolyS + 18;  // first correction stage

    // 0..6 division, 7 fix-up, 8..25 poly (partials, sum), 26 top/corr factor,
    // 27 corr partials, 28 corr sum, 29 out
    crs_pkg::word_t a_reg [Depth];
    crs_pkg::word_t y_reg [Depth];
    logic [7:0]     q_reg [Depth];
    logic           nn_reg [Depth];
    crs_pkg::word_t r_reg [Depth];
    crs_pkg::word_t pp0_reg [Depth];
    crs_pkg::word_t pp1_reg [Depth];
    crs_pkg::word_t pp2_reg [Depth];

    crs_pkg::word_t a_next [Depth];
    crs_pkg::word_t y_next [Depth];
    logic [7:0]     q_next [Depth];
    logic           nn_next [Depth];
    crs_pkg::word_t r_next [Depth];
    crs_pkg::word_t pp0_next [Depth];
    crs_pkg::word_t pp1_next [Depth];
    crs_pkg::word_t pp2_next [Depth];

    always_comb begin
        crs_pkg::word_t a0;
        crs_pkg::word_t yt;
        crs_pkg::word_t m;
        a0 = {41'd0, mag} << 9;
        yt = '0;
        m  = '0;
        for (int s = 0; s < Depth; s++) begin
            if (s == 0) begin
                a_next[s] = a0; y_next[s] = a0 >> 7; q_next[s] = '0;
                nn_next[s] = nonneg; r_next[s] = '0;
            end else begin
                a_next[s] = a_reg[s-1]; y_next[s] = y_reg[s-1]; q_next[s] = q_reg[s-1];
                nn_next[s] = nn_reg[s-1]; r_next[s] = r_reg[s-1];
            end
            pp0_next[s] = '0; pp1_next[s] = '0; pp2_next[s] = '0;
            if (s <= 6) begin
                yt = (y_next[s] << 1) | {63'd0, a_next[s][6-s]};
                if (yt >= crs_pkg::DivLn2) begin
                    q_next[s][6-s] = 1'b1;
                    yt = yt - crs_pkg::DivLn2;
                end
                y_next[s] = yt;
            end else if (s == 7) begin
                if (nn_next[s]) begin
                    y_next[s] = crs_pkg::DivLn2 - y_next[s];
                    q_next[s] = q_next[s] + 8'd1;
                end
            end else if (s < CorrS) begin
                if (((s - PolyS) % 2) == 0) begin
                    // low 64 bits of m * y from three 32 x 32 products
                    if (s == PolyS) m = crs_pkg::PolyC0;
                    else m = crs_pkg::poly_coef(4'((s - PolyS) / 2)) - r_next[s];
                    pp0_next[s] = 64'(m[31:0]) * 64'(y_next[s][31:0]);
                    pp1_next[s] = {m[31:0] * y_next[s][63:32], 32'd0};
                    pp2_next[s] = {m[63:32] * y_next[s][31:0], 32'd0};
                end else begin
                    r_next[s] = (pp0_reg[s-1] + pp1_reg[s-1] + pp2_reg[s-1])
                                >> crs_pkg::poly_shift(4'((s - PolyS) / 2));
                end
            end else if (s == CorrS) begin
                r_next[s] = crs_pkg::PolyTop - r_next[s];
                a_next[s] = crs_pkg::Corr * {56'd0, q_next[s]};
            end else if (s == CorrS + 1) begin
                // factor stays below 2^23, so its upper half is zero
                pp0_next[s] = 64'(a_next[s][31:0]) * 64'(r_next[s][31:0]);
                pp1_next[s] = {a_next[s][31:0] * r_next[s][63:32], 32'd0};
            end else if (s == CorrS + 2) begin
                a_next[s] = (pp0_reg[s-1] + pp1_reg[s-1]) >> 43;
            end else begin
                r_next[s] = nn_next[s] ? r_next[s] + a_next[s] : r_next[s] - a_next[s];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < Depth; s++) begin
                a_reg[s] <= a_next[s]; y_reg[s] <= y_next[s]; q_reg[s] <= q_next[s];
                nn_reg[s] <= nn_next[s]; r_reg[s] <= r_next[s];
                pp0_reg[s] <= pp0_next[s]; pp1_reg[s] <= pp1_next[s];
                pp2_reg[s] <= pp2_next[s];
            end
        end
    end

    assign p  = r_reg[Depth-1];
    assign ex = nn_reg[Depth-1] ? crs_pkg::exp_t'(41 - int'(q_reg[Depth-1]))
                                : crs_pkg::exp_t'(41 + int'(q_reg[Depth-1]));
endmodule

// ===== hdl/cosh_rejection_sampler_core.sv =====
// ----------------------------------------------------------------------------
// cosh_rejection_sampler_core: BLISS cosh rejection decision
// Returns one reject flag per argument/random item.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries arg_value (signed 23 bits) and random_bits (40 bits);
//   m_ channel returns reject, one item per input item, in order.
//   One item is accepted every cycle while the output side keeps up.
//   Pipeline: 1 front stage, 30 exp stages run side by side for +|x| and
//   -|x|, and 4 align, product and compare stages.
//   The whole pipe advances as one when the output register is free or
//   being taken; when the receiver stalls the pipe holds, s_ready drops,
//   and nothing is lost or repeated.
//   Reset (aresetn low, synchronous) clears all valid bits; payload is
//   not reset.
//   Stage map: abs value, exp pipes, align/add, 20 x 32 partial products,
//   product sums, split/compare.
// ----------------------------------------------------------------------------
module cosh_rejection_sampler_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [crs_pkg::ArgW-1:0] s_arg_value,
    input  logic [crs_pkg::RndW-1:0]    s_random_bits,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_reject
);
    localparam int Lat = crs_pkg::ExpDepth + 5;

    logic en;
    logic [Lat-1:0] v_reg;
    assign en      = !v_reg[Lat-1] || m_ready;
    assign s_ready = en;
    assign m_valid = v_reg[Lat-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) v_reg <= '0;
        else if (en) v_reg <= {v_reg[Lat-2:0], s_valid};
    end

    // random bits ride a delay line alongside, up to the align/add stage
    logic [crs_pkg::RndW-1:0] rnd_reg [Lat-3];
    always_ff @(posedge aclk) begin
        if (en) begin
            rnd_reg[0] <= s_random_bits;
            for (int i = 1; i < Lat-3; i++) rnd_reg[i] <= rnd_reg[i-1];
        end
    end

    // front: magnitude
    logic [crs_pkg::MagW-1:0] mag_reg;
    logic [crs_pkg::MagW-1:0] raw;
    assign raw = s_arg_value;
    always_ff @(posedge aclk) begin
        if (en) mag_reg <= raw[crs_pkg::MagW-1] ? 23'(24'h800000 - {1'b0, raw}) : raw;
    end

    crs_pkg::word_t p1, p2;
    crs_pkg::exp_t  e1, e2;
    crs_exp_pipe u_pos (
        .aclk(aclk), .en(en), .mag(mag_reg), .nonneg(1'b1), .p(p1), .ex(e1));
    crs_exp_pipe u_neg (
        .aclk(aclk), .en(en), .mag(mag_reg), .nonneg(mag_reg == '0), .p(p2), .ex(e2));

    // align and add
    crs_pkg::word_t p_reg;
    crs_pkg::exp_t  e_reg;
    crs_pkg::exp_t  gap;
    assign gap = e2 - e1;
    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= p1 + ((gap >= 0 && gap <= 40) ? p2 >> gap : 64'd0);
            e_reg <= e1 + crs_pkg::exp_t'(1);
        end
    end

    // partial products against the two 32-bit halves of p
    logic [51:0] u0l_reg, u1l_reg;
    logic [31:0] u0h_reg, u1h_reg;
    crs_pkg::exp_t  ep_reg;
    logic [crs_pkg::RndW-1:0] rnd_m;
    assign rnd_m = rnd_reg[Lat-4];
    always_ff @(posedge aclk) begin
        if (en) begin
            u0l_reg <= 52'(rnd_m[19:0]) * 52'(p_reg[31:0]);
            u1l_reg <= 52'(rnd_m[39:20]) * 52'(p_reg[31:0]);
            u0h_reg <= rnd_m[19:0] * p_reg[63:32];
            u1h_reg <= rnd_m[39:20] * p_reg[63:32];
            ep_reg  <= e_reg;
        end
    end

    // two products, modulo 2^64
    crs_pkg::word_t u0_reg, u1_reg;
    crs_pkg::exp_t  e2_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            u0_reg <= {12'd0, u0l_reg} + {u0h_reg, 32'd0};
            u1_reg <= {12'd0, u1l_reg} + {u1h_reg, 32'd0};
            e2_reg <= ep_reg;
        end
    end

    // split and compare
    crs_pkg::word_t lo, hi, one_sh;
    logic rej;
    always_comb begin
        lo = {44'd0, u0_reg[19:0]} + ({54'd0, u1_reg[9:0]} << 20);
        hi = (u0_reg >> 40) + (u1_reg >> 20) + (lo >> 40);
        lo = lo & 64'hFFFFF;
        if (e2_reg >= 0) begin
            one_sh = 64'd1 << e2_reg[5:0];
            rej = hi >= one_sh;
        end else if (e2_reg >= crs_pkg::exp_t'(-40)) begin
            one_sh = 64'd1 << 6'(e2_reg + crs_pkg::exp_t'(40));
            rej = (lo >= one_sh) || (hi != 0);
        end else begin
            one_sh = '0;
            rej = (hi != 0) || (lo != 0);
        end
    end

    logic rej_reg;
    always_ff @(posedge aclk) begin
        if (en) rej_reg <= rej;
    end
    assign m_reject = rej_reg;

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_reject)) else $error("result dropped");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready) else $error("pipe stalled while empty");
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |=> v_reg[0] == $past(s_valid)) else $error("valid lost");
endmodule

// ===== tb/sv/cosh_rejection_checker.sv =====
// ----------------------------------------------------------------------------
// cosh_rejection_checker: predicts and checks the reject flag stream
// Watches both channels, computes each reject decision and compares in order.
// ----------------------------------------------------------------------------
module cosh_rejection_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic signed [crs_pkg::ArgW-1:0] s_arg_value,
    input  logic [crs_pkg::RndW-1:0]        s_random_bits,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic                            m_reject,
    output int                              err_count,
    output int                              pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] LN2_DIV = 64'd16404853;
    localparam logic [63:0] CORR_K  = 64'd17933;

    bit reject_q[$];

    function automatic logic [63:0] horner_exp(input logic [63:0] x);
        logic [63:0] r;
        r = (64'd809438661408 * x) >> 28;
        r = ((64'd869506949331 - r) * x) >> 28;
        r = ((64'd640044208952 - r) * x) >> 27;
        r = ((64'd793458686015 - r) * x) >> 27;
        r = ((64'd839743192604 - r) * x) >> 27;
        r = ((64'd740389683060 - r) * x) >> 26;
        r = ((64'd1044449863563 - r) * x) >> 27;
        r = ((64'd552517269260 - r) * x) >> 25;
        r = ((64'd779422325990 - r) * x) >> 23;
        return 64'd2199023255552 - r;
    endfunction

    // exp of +mag (pos) or -mag; mantissa returned, exponent through ex
    function automatic logic [63:0] exp_term(input logic [63:0] mag, input bit pos,
                                             output int ex);
        logic [63:0] a, y, q, r, c;
        a = mag << 9;
        y = a >> 7;
        q = 0;
        for (int i = 6; i >= 0; i--) begin
            y = (y << 1) | ((a >> i) & 64'd1);
            if (y >= LN2_DIV) begin
                q |= 64'd1 << i;
                y -= LN2_DIV;
            end
        end
        if (pos) begin
            y = LN2_DIV - y;
            q += 1;
            ex = 41 - int'(q);
        end else begin
            ex = 41 + int'(q);
        end
        r = horner_exp(y);
        c = (CORR_K * q * r) >> 43;
        return pos ? r + c : r - c;
    endfunction

    function automatic bit reject_of(input logic [22:0] raw, input logic [39:0] rnd);
        logic [63:0] mag, p, p2, u0, u1, lo, hi;
        int e1, e2, gap;
        bit rej;
        mag = raw[22] ? (64'h800000 - 64'(raw)) : 64'(raw);
        p = exp_term(mag, 1'b1, e1);
        p2 = exp_term(mag, mag == 0, e2);
        gap = e2 - e1;
        p2 = (gap >= 0 && gap <= 40) ? p2 >> gap : 64'd0;
        p += p2;
        e1 += 1;
        u0 = 64'(rnd[19:0]) * p;
        u1 = 64'(rnd[39:20]) * p;
        lo = (u0 & 64'hFFFFF) + ((u1 & 64'h3FF) << 20);
        hi = (u0 >> 40) + (u1 >> 20) + (lo >> 40);
        lo &= 64'hFFFFF;
        if (e1 >= 0)
            rej = hi >= (64'd1 << (e1 & 63));
        else if (e1 >= -40)
            rej = (lo >= (64'd1 << ((e1 + 40) & 63))) || (hi != 0);
        else
            rej = (hi != 0) || (lo != 0);
        return rej;
    endfunction

    initial err_count = 0;
    assign pending = reject_q.size();

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                reject_q.push_back(reject_of(s_arg_value, s_random_bits));
            if (m_valid && m_ready) begin
                if (reject_q.size() == 0) begin
                    $display("%t: unexpected item, actual reject=%0b", $time, m_reject);
                    err_count <= err_count + 1;
                end else begin
                    bit want;
                    want = reject_q.pop_front();
                    if (want !== m_reject) begin
                        $display("%t: reject mismatch, expected=%0b actual=%0b",
                                 $time, want, m_reject);
                        err_count <= err_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== tb/sv/tb_cosh_rejection_sampler_core.sv =====
// ----------------------------------------------------------------------------
// tb_cosh_rejection_sampler_core: stimulus and verdict for the sampler
// Directed corner items then random arguments/bits, random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_cosh_rejection_sampler_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_RANDOM = 900;
    localparam int MAX_CYCLES = 200000;
    localparam int MAX_ARG    = 2787566;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic signed [22:0] s_arg_value = '0;
    logic [39:0] s_random_bits = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_reject;
    int          err_count;
    int          pending;
    int          cycle_cnt = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    cosh_rejection_sampler_core i_dut (
        .aclk, .aresetn, .s_valid, .s_ready, .s_arg_value, .s_random_bits,
        .m_valid, .m_ready, .m_reject
    );

    cosh_rejection_checker i_chk (
        .aclk, .aresetn, .s_valid, .s_ready, .s_arg_value, .s_random_bits,
        .m_valid, .m_ready, .m_reject, .err_count, .pending
    );

    // watchdog: far beyond worst case of the largest gaps and stalls per item
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > MAX_CYCLES) begin
            $display("tb_cosh_rejection_sampler_core: errors");
            $finish;
        end
    end

    // receiver: random stall per item, some stretches of none
    initial begin
        int hold;
        @(posedge aclk iff aresetn);
        forever begin
            hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            if (hold > 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk iff m_valid);
        end
    end

    // one item: optional gap, then hold valid until accepted
    task automatic send_item(input logic signed [22:0] arg, input logic [39:0] rnd,
                             input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_arg_value   <= arg;
        s_random_bits <= rnd;
        @(posedge aclk iff s_ready);
    endtask

    function automatic int draw_gap();
        return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
    endfunction

    initial begin
        logic [39:0] rnd;
        logic signed [22:0] arg;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: zero argument, range ends, out-of-range, random extremes
        send_item(23'sd0, 40'd0, 0);
        send_item(23'sd0, {40{1'b1}}, 0);
        send_item(23'sd0, 40'h80000_80000, 0);
        send_item(23'(MAX_ARG), 40'd0, 0);
        send_item(23'(MAX_ARG), {40{1'b1}}, 0);
        send_item(-23'(MAX_ARG), 40'd1, 0);
        send_item(-23'(MAX_ARG), {40{1'b1}}, 0);
        send_item(23'sd1, 40'h00000_FFFFF, 0);
        send_item(-23'sd1, 40'hFFFFF_00000, 0);
        send_item(23'sh3FFFFF, 40'h12345_6789A, 0);   // largest positive raw
        send_item(23'sh400000, 40'hFFFFF_FFFFF, 0);   // most negative raw
        send_item(23'sh400001, 40'h00001_00001, 0);
        send_item(23'sh2AAAAA, 40'hAAAAA_AAAAA, 3);
        send_item(23'sh555555, 40'h55555_55555, 0);
        send_item(23'(16404853 >> 9), 40'h7FFFF_FFFFF, 0);

        // hold off until the pipe has drained
        s_valid <= 1'b0;
        @(posedge aclk iff pending == 0);

        for (int n = 0; n < NUM_RANDOM; n++) begin
            rnd = 40'({$urandom(), $urandom()});
            case ($urandom_range(0, 9))
                0:       arg = 23'($urandom());                // full field incl. out of range
                1:       arg = 23'($urandom_range(0, 64)) - 23'sd32;
                default: arg = 23'($signed($urandom_range(0, 2 * MAX_ARG)) - MAX_ARG);
            endcase
            // small random words exercise the low exponent ranges
            if ($urandom_range(0, 7) == 0)
                rnd = rnd >> $urandom_range(0, 39);
            send_item(arg, rnd, (n % 150 < 30) ? 0 : draw_gap());
            if (n == NUM_RANDOM / 2) begin
                s_valid <= 1'b0;
                @(posedge aclk iff pending == 0);
            end
        end
        s_valid <= 1'b0;

        @(posedge aclk iff pending == 0);
        repeat (40) @(posedge aclk);
        if (err_count == 0)
            $display("tb_cosh_rejection_sampler_core: clean");
        else
            $display("tb_cosh_rejection_sampler_core: errors");
        $finish;
    end
endmodule
